// ===== design/deq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

   localparam int DEPTH    = 16;
   localparam int DATA_W   = 32;
   localparam int COUNT_W  = $clog2(DEPTH + 1);
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [COUNT_W-1:0]       count_type;
   typedef logic [CMD_W-1:0]         cmd_type;
   typedef logic [STATUS_W-1:0]      status_type;

   localparam cmd_type CMD_PUSH_BACK  = 2'd0;
   localparam cmd_type CMD_PUSH_FRONT = 2'd1;
   localparam cmd_type CMD_POP_BACK   = 2'd2;
   localparam cmd_type CMD_POP_FRONT  = 2'd3;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_EMPTY = 2'd1;
   localparam status_type STATUS_FULL  = 2'd2;

   localparam data_type NO_VALUE = '1;

   localparam count_type COUNT_FULL = COUNT_W'(DEPTH);

   // Qualified operation broadcast to every cell; at most one bit is set.
   typedef struct packed {
      logic push_back;
      logic push_front;
      logic pop_back;
      logic pop_front;
   } op_type;

endpackage

`default_nettype wire

// ===== design/deq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module deq_cell (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire deq_pkg::op_type  op,
   input  wire deq_pkg::data_type push_data,
   input  wire deq_pkg::data_type left_data,
   input  wire logic             left_valid,
   input  wire deq_pkg::data_type right_data,
   input  wire logic             right_valid,
   output deq_pkg::data_type     data_out,
   output logic                  valid_out
);
   import deq_pkg::*;

   data_type data_ff;
   data_type data_in;
   logic     valid_ff;
   logic     valid_in;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      priority if (op.push_front) begin
         // shift toward the back
         data_in  = left_data;
         valid_in = left_valid;
      end else if (op.pop_front) begin
         // shift toward the front
         data_in  = right_data;
         valid_in = right_valid;
      end else if (op.push_back) begin
         // first free cell takes the value
         if (!valid_ff && left_valid) begin
            data_in  = push_data;
            valid_in = 1'b1;
         end
      end else if (op.pop_back) begin
         // last occupied cell drops its entry
         if (valid_ff && !right_valid) begin
            valid_in = 1'b0;
         end
      end else begin
         // hold
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign data_out  = data_ff;
   assign valid_out = valid_ff;

endmodule

`default_nettype wire

// ===== design/double_ended_queue_core.sv =====
// Channel   Direction  Handshake           Payload
// req_      in         req_valid/ready     req_command, req_value
// rsp_      out        rsp_valid/ready     rsp_popped_value, rsp_status,
//                                          rsp_is_empty, rsp_entry_count
//
// One request per cycle unless the response stalls; the response is registered.
// Entries live in a row of DEPTH cells packed from the front: front operations
// shift the whole row, back operations touch only the cell at the back end.
// Reset (synchronous) empties the row and clears the response valid flag.
// A stalled response holds; a new request is taken in the cycle the held
// response leaves.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire deq_pkg::cmd_type   req_command,
   input  wire deq_pkg::data_type  req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output deq_pkg::data_type       rsp_popped_value,
   output deq_pkg::status_type     rsp_status,
   output logic                    rsp_is_empty,
   output deq_pkg::count_type      rsp_entry_count
);
   import deq_pkg::*;

   // Cell row
   data_type         cell_data  [DEPTH];
   logic [DEPTH-1:0] cell_valid;
   logic [DEPTH-1:0] cell_last;
   op_type           op;

   // Control state
   count_type count_ff;
   count_type count_in;

   // Response register
   logic       rsp_valid_ff;
   data_type   rsp_value_ff;
   status_type rsp_status_ff;
   logic       rsp_empty_ff;
   count_type  rsp_count_ff;

   logic       accept;
   logic       is_push;
   logic       full;
   logic       empty;
   data_type   back_data;
   data_type   pop_data;
   status_type status_now;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_push   = (req_command == CMD_PUSH_BACK) || (req_command == CMD_PUSH_FRONT);
   assign full      = (count_ff == COUNT_FULL);
   assign empty     = (count_ff == '0);

   // Qualify the command: a rejected push or an empty pop leaves the row alone.
   always_comb begin
      op = '0;
      if (accept) begin
         unique case (req_command)
            CMD_PUSH_BACK:  op.push_back  = !full;
            CMD_PUSH_FRONT: op.push_front = !full;
            CMD_POP_BACK:   op.pop_back   = !empty;
            CMD_POP_FRONT:  op.pop_front  = !empty;
            default:        op = '0;
         endcase
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      data_type left_data;
      logic     left_valid;
      data_type right_data;
      logic     right_valid;

      if (i == 0) begin : g_head
         // Head cell sees the incoming value as its left neighbor.
         assign left_data  = req_value;
         assign left_valid = 1'b1;
      end else begin : g_body
         assign left_data  = cell_data[i-1];
         assign left_valid = cell_valid[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_data  = cell_data[i];
         assign right_valid = 1'b0;
      end else begin : g_inner
         assign right_data  = cell_data[i+1];
         assign right_valid = cell_valid[i+1];
      end

      deq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .op          (op),
         .push_data   (req_value),
         .left_data   (left_data),
         .left_valid  (left_valid),
         .right_data  (right_data),
         .right_valid (right_valid),
         .data_out    (cell_data[i]),
         .valid_out   (cell_valid[i])
      );

      assign cell_last[i] = cell_valid[i] && !right_valid;
   end

   // Pick the back entry: exactly one cell is last when the row is not empty.
   always_comb begin
      back_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         back_data = back_data | (cell_data[i] & {DATA_W{cell_last[i]}});
      end
   end

   always_comb begin
      count_in   = count_ff;
      pop_data   = NO_VALUE;
      status_now = STATUS_OK;
      if (is_push) begin
         if (full) begin
            status_now = STATUS_FULL;
         end else begin
            count_in = count_ff + COUNT_W'(1);
         end
      end else begin
         if (empty) begin
            status_now = STATUS_EMPTY;
         end else begin
            count_in = count_ff - COUNT_W'(1);
            pop_data = (req_command == CMD_POP_FRONT) ? cell_data[0] : back_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            // drop the delivered response
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_value_ff  <= pop_data;
         rsp_status_ff <= status_now;
         rsp_empty_ff  <= (count_in == '0);
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_is_empty     = rsp_empty_ff;
   assign rsp_entry_count  = rsp_count_ff;

   // Occupancy counter tracks the cell valid bits.
   assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(count_ff))
      else $error("count does not match occupied cells");

   // Occupied cells stay packed at the front of the row.
   assert property (@(posedge clock) disable iff (reset)
      (cell_valid & (cell_valid + DEPTH'(1))) == '0)
      else $error("gap in occupied cells");

   // A push on a full queue is flagged and leaves the count alone.
   assert property (@(posedge clock) disable iff (reset)
      accept && is_push && full |=> rsp_status == STATUS_FULL && $stable(count_ff))
      else $error("full push not rejected");

   // A pop on an empty queue returns all ones.
   assert property (@(posedge clock) disable iff (reset)
      accept && !is_push && empty |=> rsp_popped_value == NO_VALUE && rsp_is_empty)
      else $error("empty pop result wrong");

endmodule

`default_nettype wire

// ===== sim/deque_checker.sv =====
`timescale 1ns / 1ps

module deque_checker (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire deq_pkg::cmd_type     req_command,
   input  wire deq_pkg::data_type    req_value,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire deq_pkg::data_type    rsp_popped_value,
   input  wire deq_pkg::status_type  rsp_status,
   input  wire logic                 rsp_is_empty,
   input  wire deq_pkg::count_type   rsp_entry_count,
   output int                        failures,
   output int                        outstanding
);
   import deq_pkg::*;

   typedef struct {
      data_type   popped_value;
      status_type status;
      logic       is_empty;
      count_type  entry_count;
   } deque_reply;

   // Shadow ring: head points at the first entry, tail one past the last.
   data_type   ring [DEPTH];
   int         head_idx;
   int         tail_idx;
   int         fill_level;
   deque_reply expected_replies [$];
   int         mismatch_total;

   function automatic deque_reply apply_command(cmd_type cmd, data_type value);
      deque_reply reply;
      reply.popped_value = NO_VALUE;
      reply.status       = STATUS_OK;
      case (cmd)
         CMD_PUSH_BACK: begin
            if (fill_level >= DEPTH) begin
               reply.status = STATUS_FULL;
            end else begin
               ring[tail_idx] = value;
               tail_idx = (tail_idx + 1) % DEPTH;
               fill_level++;
            end
         end
         CMD_PUSH_FRONT: begin
            if (fill_level >= DEPTH) begin
               reply.status = STATUS_FULL;
            end else begin
               head_idx = (head_idx + DEPTH - 1) % DEPTH;
               ring[head_idx] = value;
               fill_level++;
            end
         end
         CMD_POP_BACK: begin
            if (fill_level == 0) begin
               reply.status = STATUS_EMPTY;
            end else begin
               tail_idx = (tail_idx + DEPTH - 1) % DEPTH;
               reply.popped_value = ring[tail_idx];
               fill_level--;
            end
         end
         CMD_POP_FRONT: begin
            if (fill_level == 0) begin
               reply.status = STATUS_EMPTY;
            end else begin
               reply.popped_value = ring[head_idx];
               head_idx = (head_idx + 1) % DEPTH;
               fill_level--;
            end
         end
      endcase
      reply.is_empty    = (fill_level == 0);
      reply.entry_count = count_type'(fill_level);
      return reply;
   endfunction

   always @(posedge clock) begin
      deque_reply want;
      if (reset) begin
         head_idx   = 0;
         tail_idx   = 0;
         fill_level = 0;
         expected_replies.delete();
      end else begin
         // Retire the response first: it always belongs to an older request.
         if (rsp_valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               mismatch_total++;
               $display("%0t: unexpected response, value %0d status %0d", $time,
                        rsp_popped_value, rsp_status);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_popped_value !== want.popped_value) begin
                  mismatch_total++;
                  $display("%0t: popped_value expected %0d, got %0d", $time,
                           want.popped_value, rsp_popped_value);
               end
               if (rsp_status !== want.status) begin
                  mismatch_total++;
                  $display("%0t: status expected %0d, got %0d", $time,
                           want.status, rsp_status);
               end
               if (rsp_is_empty !== want.is_empty) begin
                  mismatch_total++;
                  $display("%0t: is_empty expected %0d, got %0d", $time,
                           want.is_empty, rsp_is_empty);
               end
               if (rsp_entry_count !== want.entry_count) begin
                  mismatch_total++;
                  $display("%0t: entry_count expected %0d, got %0d", $time,
                           want.entry_count, rsp_entry_count);
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_replies.push_back(apply_command(req_command, req_value));
         end
      end
      failures    <= mismatch_total;
      outstanding <= expected_replies.size();
   end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import deq_pkg::*;

   localparam int CLOCK_PERIOD = 8;
   localparam int RESET_CYCLES = 9;
   localparam int RANDOM_ITEMS = 1600;
   localparam int LONG_HOLD    = 80;
   localparam int TIMEOUT_NS   = 5_000_000;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   cmd_type    req_command;
   data_type   req_value;
   logic       rsp_valid;
   logic       rsp_ready;
   data_type   rsp_popped_value;
   status_type rsp_status;
   logic       rsp_is_empty;
   count_type  rsp_entry_count;

   int failures;
   int outstanding;

   // Idle rates in percent, changed per burst by the stimulus; zero means a
   // stretch with no idling on that side.
   int req_gap_pct;
   int rsp_stall_pct;
   // Raised by the stimulus to make the receiver hold off for a long stretch.
   bit long_hold_req;

   double_ended_queue_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_popped_value (rsp_popped_value),
      .rsp_status       (rsp_status),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_entry_count  (rsp_entry_count)
   );

   deque_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_popped_value (rsp_popped_value),
      .rsp_status       (rsp_status),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_entry_count  (rsp_entry_count),
      .failures         (failures),
      .outstanding      (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #(TIMEOUT_NS);
      $display("tb_top: errors");
      $finish;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      if ($urandom_range(9) == 0) begin
         return $urandom_range(12, 40);
      end
      return $urandom_range(1, 3);
   endfunction

   // Bias toward the sign and zero corners, otherwise uniform.
   function automatic data_type pick_value();
      case ($urandom_range(15))
         0:       return data_type'(32'h8000_0000);
         1:       return data_type'(32'h7FFF_FFFF);
         2:       return '0;
         3:       return NO_VALUE;
         default: return data_type'($urandom);
      endcase
   endfunction

   // Offer one transaction, optionally after an idle gap, and hold it until
   // taken. Returns in the time step of the accepting edge.
   task automatic send_command(cmd_type cmd, data_type value);
      int gap;
      gap = ($urandom_range(99) < req_gap_pct) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_value   <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // Advance one edge first so a transaction taken at this edge is counted.
   task automatic wait_for_drain();
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Receiver: count stalls locally so a long hold-off runs to its end.
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left    = LONG_HOLD;
         end else if ($urandom_range(99) < rsp_stall_pct) begin
            stall_left = pick_gap();
         end
         rsp_ready <= (stall_left == 0);
      end
   end

   initial begin : stimulus
      int      sent;
      int      burst_len;
      int      push_pct;
      bit      hold_done;
      bit      drain_done;
      cmd_type cmd;

      sent          = 0;
      hold_done     = 1'b0;
      drain_done    = 1'b0;
      long_hold_req = 1'b0;
      req_gap_pct   = 30;
      rsp_stall_pct = 30;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_command <= CMD_PUSH_BACK;
      req_value   <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: pop both ends of the empty queue, fill it from alternating
      // ends with the value corners, push both ends when full, then pop a few.
      send_command(CMD_POP_BACK, data_type'($urandom));
      send_command(CMD_POP_FRONT, data_type'($urandom));
      for (int i = 0; i < DEPTH; i++) begin
         send_command((i % 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                      (i == 0) ? data_type'(32'h8000_0000) :
                      (i == 1) ? data_type'(32'h7FFF_FFFF) :
                      (i == 2) ? data_type'(0) :
                      (i == 3) ? NO_VALUE : data_type'($urandom));
      end
      send_command(CMD_PUSH_BACK, data_type'($urandom));
      send_command(CMD_PUSH_FRONT, data_type'($urandom));
      send_command(CMD_POP_FRONT, data_type'($urandom));
      send_command(CMD_POP_BACK, data_type'($urandom));
      send_command(CMD_POP_FRONT, data_type'($urandom));
      send_command(CMD_POP_BACK, data_type'($urandom));

      // Random bursts: push-heavy bursts drive the queue to full, pop-heavy
      // ones drain it to empty, balanced ones wander around the ring.
      while (sent < RANDOM_ITEMS) begin
         burst_len = $urandom_range(8, 48);
         case ($urandom_range(2))
            0:       push_pct = 80;
            1:       push_pct = 20;
            default: push_pct = 50;
         endcase
         req_gap_pct   = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 60);
         rsp_stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 60);
         if (!hold_done && sent > 400) begin
            // Hold off the receiver and keep offering so the input stalls.
            hold_done     = 1'b1;
            req_gap_pct   = 0;
            long_hold_req = 1'b1;
         end
         if (!drain_done && sent > 900) begin
            // Pause the sender until every response is back.
            drain_done = 1'b1;
            req_valid <= 1'b0;
            wait_for_drain();
         end
         repeat (burst_len) begin
            if ($urandom_range(99) < push_pct) begin
               cmd = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
            end else begin
               cmd = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
            end
            send_command(cmd, pick_value());
            sent++;
         end
      end
      req_valid <= 1'b0;

      wait_for_drain();
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
